// File: design/ftc_pkg.sv
// Shared constants, register indexes and types for the floor texel caster.
package ftc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int TILE_SIZE  = 16;
    localparam int MAX_SCREEN = 4096;

    localparam int TEX_W   = $clog2(TILE_SIZE);
    localparam int SCR_W   = 13;
    localparam int PIX_W   = 12;
    localparam int DEN_W   = 13;
    localparam int MAG_W   = 32;
    localparam int DVD_W   = 46;
    localparam int ZD_W    = DVD_W + 1;
    localparam int PROD_W  = 64;
    localparam int SUM_W   = PROD_W - 14 + 2;
    localparam int ADDR_W  = 5;

    localparam logic [2:0] REG_CAM_X      = 3'd0;
    localparam logic [2:0] REG_CAM_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CAM_Z      = 3'd2;
    localparam logic [2:0] REG_ROT_SIN    = 3'd3;
    localparam logic [2:0] REG_ROT_COS    = 3'd4;
    localparam logic [2:0] REG_SCR_WIDTH  = 3'd5;
    localparam logic [2:0] REG_SCR_HEIGHT = 3'd6;

    typedef struct packed {
        logic horizon;
        logic num_neg;
        logic px_neg;
    } ftc_side_t;

endpackage

// File: design/floor_texel_caster.sv
// Top level of the floor texel caster: config registers, front end, divider, rotation and output.
//
// Usage: pixels enter on pixel_valid/pixel_ready with pixel_x and pixel_y; each transfer
// yields one result on texel_valid/texel_ready carrying tex_u, tex_v, depth and
// depth_saturated, in input order.
// Camera and screen registers are written over the APB port (pready tied high). The user
// must write them only while idle; the block does not enforce it. Pipeline: 2 front stages,
// 46 divider stages at one quotient bit each, 4 back stages; one pixel per cycle unless stalled.
// Every stage holds its own valid bit; a stage whose successor is empty or moving takes
// new data, so bubbles close up and a stalled receiver only backs up the pipeline
// stage by stage. The final output register holds its result until transferred.
// Reset clears all valid bits and loads the register defaults (cos 1.0, 320 by 240).
module floor_texel_caster
    import ftc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                pixel_valid,
    output logic                pixel_ready,
    input  logic [PIX_W-1:0]    pixel_x,
    input  logic [PIX_W-1:0]    pixel_y,
    output logic                texel_valid,
    input  logic                texel_ready,
    output logic [TEX_W-1:0]    tex_u,
    output logic [TEX_W-1:0]    tex_v,
    output logic signed [31:0]  depth,
    output logic                depth_saturated
);

    localparam logic signed [33:0] EIGHT = 34'(8) <<< FRAC_BITS;

    // configuration registers
    logic signed [31:0] cam_x_reg;
    logic signed [31:0] cam_height_reg;
    logic signed [31:0] cam_z_reg;
    logic signed [15:0] rot_sin_reg;
    logic signed [15:0] rot_cos_reg;
    logic [SCR_W-1:0]   scr_width_reg;
    logic [SCR_W-1:0]   scr_height_reg;
    logic [2:0]         reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg      <= '0;
            cam_height_reg <= '0;
            cam_z_reg      <= '0;
            rot_sin_reg    <= '0;
            rot_cos_reg    <= 16'sd16384;
            scr_width_reg  <= 13'd320;
            scr_height_reg <= 13'd240;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_CAM_X:      cam_x_reg      <= pwdata;
                REG_CAM_HEIGHT: cam_height_reg <= pwdata;
                REG_CAM_Z:      cam_z_reg      <= pwdata;
                REG_ROT_SIN:    rot_sin_reg    <= pwdata[15:0];
                REG_ROT_COS:    rot_cos_reg    <= pwdata[15:0];
                REG_SCR_WIDTH:  scr_width_reg  <= pwdata[SCR_W-1:0];
                REG_SCR_HEIGHT: scr_height_reg <= pwdata[SCR_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CAM_X:      prdata = cam_x_reg;
            REG_CAM_HEIGHT: prdata = cam_height_reg;
            REG_CAM_Z:      prdata = cam_z_reg;
            REG_ROT_SIN:    prdata = {16'd0, rot_sin_reg};
            REG_ROT_COS:    prdata = {16'd0, rot_cos_reg};
            REG_SCR_WIDTH:  prdata = {19'd0, scr_width_reg};
            REG_SCR_HEIGHT: prdata = {19'd0, scr_height_reg};
            default:        prdata = '0;
        endcase
    end

    // handshake chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic r1, r2, r3, r4, r5, r6;
    logic div_in_ready, div_out_valid;

    assign r6 = !v6_reg || texel_ready;
    assign r5 = !v5_reg || r6;
    assign r4 = !v4_reg || r5;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || div_in_ready;
    assign r1 = !v1_reg || r2;
    assign pixel_ready = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= pixel_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= div_out_valid;
            if (r4) v4_reg <= v3_reg;
            if (r5) v5_reg <= v4_reg;
            if (r6) v6_reg <= v5_reg;
        end
    end

    // stage 1: slope denominator, numerator sign and magnitudes
    logic [SCR_W-1:0]   h_eff, w_eff;
    logic signed [14:0] d_next, dx_next;
    logic signed [33:0] num_next;
    logic [DEN_W-1:0]   dmag_next, dxmag_next;
    logic [MAG_W-1:0]   nmag_next;
    ftc_side_t          side_next;

    always_comb
    begin
        w_eff = (scr_width_reg > SCR_W'(MAX_SCREEN)) ? SCR_W'(MAX_SCREEN) : scr_width_reg;
        h_eff = (scr_height_reg > SCR_W'(MAX_SCREEN)) ? SCR_W'(MAX_SCREEN) : scr_height_reg;
        if (h_eff == '0)
        begin
            h_eff = SCR_W'(1);
        end
        d_next  = $signed({2'b00, pixel_y, 1'b1}) - $signed({2'b00, h_eff});
        dx_next = $signed({2'b00, pixel_x, 1'b0}) - $signed({2'b00, w_eff});
        if (d_next < 0)
        begin
            num_next  = EIGHT - 34'(cam_height_reg);
            dmag_next = DEN_W'(-d_next);
        end
        else
        begin
            num_next  = EIGHT + 34'(cam_height_reg);
            dmag_next = DEN_W'(d_next);
        end
        nmag_next  = (num_next < 0) ? MAG_W'(-num_next) : MAG_W'(num_next);
        dxmag_next = (dx_next < 0) ? DEN_W'(-dx_next) : DEN_W'(dx_next);
        side_next.horizon = (dmag_next == '0);
        side_next.num_neg = (num_next < 0);
        side_next.px_neg  = (num_next < 0) ^ (dx_next < 0);
    end

    logic [MAG_W-1:0] nmag1_reg;
    logic [SCR_W:0]   twoh1_reg;
    logic [DEN_W-1:0] dxmag1_reg, dmag1_reg;
    ftc_side_t        side1_reg;

    always_ff @(posedge clk)
    begin
        if (r1 && pixel_valid)
        begin
            nmag1_reg  <= nmag_next;
            twoh1_reg  <= {h_eff, 1'b0};
            dxmag1_reg <= dxmag_next;
            dmag1_reg  <= dmag_next;
            side1_reg  <= side_next;
        end
    end

    // stage 2: dividend products
    logic [DVD_W-1:0] dvda2_reg, dvdb2_reg;
    logic [DEN_W-1:0] dmag2_reg;
    ftc_side_t        side2_reg;

    always_ff @(posedge clk)
    begin
        if (r2 && v1_reg)
        begin
            dvda2_reg <= DVD_W'(nmag1_reg * twoh1_reg);
            dvdb2_reg <= DVD_W'(nmag1_reg * dxmag1_reg);
            dmag2_reg <= dmag1_reg;
            side2_reg <= side1_reg;
        end
    end

    logic [DVD_W-1:0] quo_a, quo_b;
    ftc_side_t        div_side;

    ftc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_ready  (div_in_ready),
        .in_dvd_a  (dvda2_reg),
        .in_dvd_b  (dvdb2_reg),
        .in_dvs    (dmag2_reg),
        .in_side   (side2_reg),
        .out_valid (div_out_valid),
        .out_ready (r3),
        .out_quo_a (quo_a),
        .out_quo_b (quo_b),
        .out_side  (div_side)
    );

    // stage 3: signed row distance and lateral offset
    logic signed [ZD_W-1:0] zd3_reg, px3_reg;
    ftc_side_t              side3_reg;

    always_ff @(posedge clk)
    begin
        if (r3 && div_out_valid)
        begin
            zd3_reg   <= div_side.num_neg ? -$signed({1'b0, quo_a}) : $signed({1'b0, quo_a});
            px3_reg   <= div_side.px_neg  ? -$signed({1'b0, quo_b}) : $signed({1'b0, quo_b});
            side3_reg <= div_side;
        end
    end

    // stage 4: rotation products
    logic signed [PROD_W-1:0] pcs4_reg, zsn4_reg, psn4_reg, zcs4_reg;
    logic signed [ZD_W-1:0]   zd4_reg;
    ftc_side_t                side4_reg;

    always_ff @(posedge clk)
    begin
        if (r4 && v3_reg)
        begin
            pcs4_reg  <= PROD_W'(px3_reg * rot_cos_reg);
            zsn4_reg  <= PROD_W'(zd3_reg * rot_sin_reg);
            psn4_reg  <= PROD_W'(px3_reg * rot_sin_reg);
            zcs4_reg  <= PROD_W'(zd3_reg * rot_cos_reg);
            zd4_reg   <= zd3_reg;
            side4_reg <= side3_reg;
        end
    end

    // stage 5: floor shift and camera offsets
    logic signed [PROD_W-1:0] xrot_next, yrot_next;
    logic signed [SUM_W-1:0]  xx5_reg, yy5_reg;
    logic signed [ZD_W-1:0]   zd5_reg;
    ftc_side_t                side5_reg;

    assign xrot_next = (pcs4_reg - zsn4_reg) >>> 14;
    assign yrot_next = (psn4_reg + zcs4_reg) >>> 14;

    always_ff @(posedge clk)
    begin
        if (r5 && v4_reg)
        begin
            xx5_reg   <= SUM_W'(xrot_next) + SUM_W'(cam_x_reg) + SUM_W'(EIGHT);
            yy5_reg   <= SUM_W'(yrot_next) + SUM_W'(cam_z_reg);
            zd5_reg   <= zd4_reg;
            side5_reg <= side4_reg;
        end
    end

    // stage 6: texel index, depth clamp, output register
    function automatic logic [TEX_W-1:0] texel_of(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] q;
        mag = (v < 0) ? SUM_W'(-v) : SUM_W'(v);
        q   = mag >> FRAC_BITS;
        return (v < 0) ? ~q[TEX_W-1:0] : q[TEX_W-1:0];
    endfunction

    logic              zd_ovf;
    logic signed [31:0] depth_next;
    logic              sat_next;

    always_comb
    begin
        zd_ovf = (zd5_reg > ZD_W'(33'sh7FFFFFFF)) || (zd5_reg < -ZD_W'(33'sh80000000));
        if (side5_reg.horizon)
        begin
            depth_next = side5_reg.num_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
            sat_next   = 1'b1;
        end
        else if (zd_ovf)
        begin
            depth_next = zd5_reg[ZD_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
            sat_next   = 1'b1;
        end
        else
        begin
            depth_next = zd5_reg[31:0];
            sat_next   = 1'b0;
        end
    end

    logic [TEX_W-1:0]   tex_u_reg, tex_v_reg;
    logic signed [31:0] depth_reg;
    logic               sat_reg;

    always_ff @(posedge clk)
    begin
        if (r6 && v5_reg)
        begin
            tex_u_reg <= side5_reg.horizon ? '0 : texel_of(xx5_reg);
            tex_v_reg <= side5_reg.horizon ? '0 : texel_of(yy5_reg);
            depth_reg <= depth_next;
            sat_reg   <= sat_next;
        end
    end

    assign texel_valid     = v6_reg;
    assign tex_u           = tex_u_reg;
    assign tex_v           = tex_v_reg;
    assign depth           = depth_reg;
    assign depth_saturated = sat_reg;

endmodule

// File: design/ftc_divider.sv
// Pipelined restoring divider, two dividends over one divisor, one quotient bit per stage.
module ftc_divider
    import ftc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [DVD_W-1:0] in_dvd_a,
    input  logic [DVD_W-1:0] in_dvd_b,
    input  logic [DEN_W-1:0] in_dvs,
    input  ftc_side_t        in_side,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [DVD_W-1:0] out_quo_a,
    output logic [DVD_W-1:0] out_quo_b,
    output ftc_side_t        out_side
);

    localparam int WW = DVD_W + DEN_W;

    function automatic logic [WW-1:0] div_step(input logic [WW-1:0] w,
                                               input logic [DEN_W-1:0] dvs);
        logic [DEN_W:0] t;
        logic [DEN_W:0] r;
        logic           ge;
        t  = {w[WW-1:DVD_W], w[DVD_W-1]};
        ge = (t >= {1'b0, dvs});
        r  = ge ? (t - {1'b0, dvs}) : t;
        return {r[DEN_W-1:0], w[DVD_W-2:0], ge};
    endfunction

    logic [WW-1:0]    wa_reg   [DVD_W];
    logic [WW-1:0]    wb_reg   [DVD_W];
    logic [DEN_W-1:0] dvs_reg  [DVD_W];
    ftc_side_t        side_reg [DVD_W];
    logic [DVD_W-1:0] vld_reg;
    logic [DVD_W:0]   rdy;

    logic [WW-1:0]    wa_in   [DVD_W];
    logic [WW-1:0]    wb_in   [DVD_W];
    logic [DEN_W-1:0] dvs_in  [DVD_W];
    ftc_side_t        side_in [DVD_W];
    logic [DVD_W-1:0] vld_in;

    assign rdy[DVD_W] = out_ready;
    assign in_ready   = rdy[0];

    genvar j;
    generate
        for (j = 0; j < DVD_W; j++)
        begin : g_stage
            if (j == 0)
            begin : g_first
                assign wa_in[j]   = {{DEN_W{1'b0}}, in_dvd_a};
                assign wb_in[j]   = {{DEN_W{1'b0}}, in_dvd_b};
                assign dvs_in[j]  = in_dvs;
                assign side_in[j] = in_side;
                assign vld_in[j]  = in_valid;
            end
            else
            begin : g_next
                assign wa_in[j]   = wa_reg[j-1];
                assign wb_in[j]   = wb_reg[j-1];
                assign dvs_in[j]  = dvs_reg[j-1];
                assign side_in[j] = side_reg[j-1];
                assign vld_in[j]  = vld_reg[j-1];
            end

            assign rdy[j] = !vld_reg[j] || rdy[j+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[j] <= 1'b0;
                end
                else if (rdy[j])
                begin
                    vld_reg[j] <= vld_in[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[j] && vld_in[j])
                begin
                    wa_reg[j]   <= div_step(wa_in[j], dvs_in[j]);
                    wb_reg[j]   <= div_step(wb_in[j], dvs_in[j]);
                    dvs_reg[j]  <= dvs_in[j];
                    side_reg[j] <= side_in[j];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[DVD_W-1];
    assign out_quo_a = wa_reg[DVD_W-1][DVD_W-1:0];
    assign out_quo_b = wb_reg[DVD_W-1][DVD_W-1:0];
    assign out_side  = side_reg[DVD_W-1];

endmodule
